// ----- hdl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FUNC_W     = 3;
    localparam int Q_W        = 32;
    localparam int STAT_W     = 2;
    localparam int ITER_STEPS = 32;

    localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MAG = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd2;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    // divide and square-root iteration payload
    typedef struct packed {
        logic [63:0]     den;
        logic [63:0]     rem_re;
        logic [63:0]     rem_im;
        logic [15:0]     lo_re;
        logic [15:0]     lo_im;
        logic [31:0]     q_re;
        logic [31:0]     q_im;
        logic            neg_re;
        logic            neg_im;
        logic            ovf_re;
        logic            ovf_im;
        logic [63:0]     sq_n;
        logic [33:0]     sq_rem;
        logic [31:0]     sq_root;
        logic            is_div;
        logic            is_mag;
        logic [Q_W-1:0]  rr;
        logic [Q_W-1:0]  ri;
        logic [STAT_W-1:0] st;
    } cau_iter_t;

endpackage

// ----- hdl/cau_iter_stage.sv -----
// ----------------------------------------------------------------------------
// cau_iter_stage
// One registered step of the two restoring dividers and the square root.
// ----------------------------------------------------------------------------
module cau_iter_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  cau_pkg::cau_iter_t in_data,
    input  logic              advance,
    output logic              out_valid,
    output cau_pkg::cau_iter_t out_data
);
    import cau_pkg::*;

    logic      valid_reg;
    cau_iter_t data_reg;
    cau_iter_t data_next;
    logic [63:0] sh_re, sh_im;
    logic [35:0] sq_sh, sq_trial;

    always_comb begin
        data_next = in_data;
        sh_re = {in_data.rem_re[62:0], in_data.lo_re[15]};
        sh_im = {in_data.rem_im[62:0], in_data.lo_im[15]};
        data_next.lo_re = {in_data.lo_re[14:0], 1'b0};
        data_next.lo_im = {in_data.lo_im[14:0], 1'b0};
        if (sh_re >= in_data.den) begin
            data_next.rem_re = sh_re - in_data.den;
            data_next.q_re   = {in_data.q_re[30:0], 1'b1};
        end else begin
            data_next.rem_re = sh_re;
            data_next.q_re   = {in_data.q_re[30:0], 1'b0};
        end
        if (sh_im >= in_data.den) begin
            data_next.rem_im = sh_im - in_data.den;
            data_next.q_im   = {in_data.q_im[30:0], 1'b1};
        end else begin
            data_next.rem_im = sh_im;
            data_next.q_im   = {in_data.q_im[30:0], 1'b0};
        end
        sq_sh    = {in_data.sq_rem, in_data.sq_n[63:62]};
        sq_trial = {2'b00, in_data.sq_root, 2'b01};
        data_next.sq_n = {in_data.sq_n[61:0], 2'b00};
        if (sq_sh >= sq_trial) begin
            data_next.sq_rem  = 34'(sq_sh - sq_trial);
            data_next.sq_root = {in_data.sq_root[30:0], 1'b1};
        end else begin
            data_next.sq_rem  = sq_sh[33:0];
            data_next.sq_root = {in_data.sq_root[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and magnitude on signed Q16.16.
// Accepts one transaction per cycle while the output is not stalled by m_tready.
// Depth is set by the 32-step divide / square-root chain after four front stages.
// Bubbles collapse: a stage loads whenever it is empty or its successor moves.
// Reset (aresetn low, synchronous) empties all stages; no other state.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // func[2:0], a_real, a_imag, b_real, b_imag, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // res_real[31:0], res_imag, status[1:0], zero pad
);
    import cau_pkg::*;

    // stage 0: input capture
    logic                  v0_reg;
    logic [FUNC_W-1:0]     func0_reg;
    logic signed [Q_W-1:0] ar0_reg, ai0_reg, br0_reg, bi0_reg;
    // stage 1: products and saturated add/subtract results
    logic                  v1_reg;
    logic [FUNC_W-1:0]     func1_reg;
    logic signed [63:0]    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_s4_reg, p_s5_reg;
    logic signed [63:0]    p_rr_next, p_ii_next, p_ri_next, p_ir_next, p_s4_next, p_s5_next;
    logic signed [Q_W-1:0] x4, x5;
    logic [Q_W-1:0]        rr1_reg, ri1_reg, rr1_next, ri1_next;
    logic [STAT_W-1:0]     st1_reg, st1_next;
    // stage 2: sums
    logic                  v2_reg;
    logic [FUNC_W-1:0]     func2_reg;
    logic [64:0]           re2_reg, im2_reg, re2_next, im2_next;
    logic [63:0]           sq2_reg, sq2_next;
    logic [Q_W-1:0]        rr2_reg, ri2_reg;
    logic [STAT_W-1:0]     st2_reg;
    // stage 3 and iteration chain
    logic [ITER_STEPS:0]   it_valid;
    logic [ITER_STEPS:0]   it_adv;
    cau_iter_t             it_data [ITER_STEPS+1];
    logic                  v3_reg;
    cau_iter_t             d3_reg, d3_next;
    // output
    logic                  m_valid_reg;
    logic [Q_W-1:0]        res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic [STAT_W-1:0]     res_st_reg, res_st_next;

    logic adv_out, adv0, adv1, adv2;

    logic [32:0] s_re, s_im;
    logic [64:0] neg_re_v, neg_im_v;
    logic [64:0] sh_re, sh_im;
    logic [63:0] mag_re, mag_im;
    logic [32:0] fin_re, fin_im;
    logic [32:0] dq_re, dq_im;
    logic        sat_a, sat_b;
    cau_iter_t   fin;

    function automatic logic [32:0] sat33(input logic [32:0] v);
        if (v[32] != v[31]) begin
            return {1'b1, (v[32] ? Q_MIN : Q_MAX)};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] sat65(input logic [64:0] v);
        if (v[64:31] != {34{v[64]}}) begin
            return {1'b1, (v[64] ? Q_MIN : Q_MAX)};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] fin_div(input logic neg, input logic ovf,
                                            input logic [31:0] q);
        if (!neg) begin
            if (ovf || q[31]) begin
                return {1'b1, Q_MAX};
            end
            return {1'b0, q};
        end
        if (ovf || q > Q_MIN) begin
            return {1'b1, Q_MIN};
        end
        return {1'b0, 32'(32'd0 - q)};
    endfunction

    // handshake chain
    assign adv_out = !m_valid_reg || m_tready;
    assign it_adv[ITER_STEPS] = !it_valid[ITER_STEPS] || adv_out;
    genvar j;
    generate
        for (j = 0; j < ITER_STEPS; j++) begin : g_iter
            assign it_adv[j] = !it_valid[j] || it_adv[j+1];
            cau_iter_stage u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (it_valid[j]),
                .in_data   (it_data[j]),
                .advance   (it_adv[j+1]),
                .out_valid (it_valid[j+1]),
                .out_data  (it_data[j+1])
            );
        end
    endgenerate
    assign adv2     = !v2_reg || it_adv[0];
    assign adv1     = !v1_reg || adv2;
    assign adv0     = !v0_reg || adv1;
    assign s_tready = adv0;

    assign it_valid[0] = v3_reg;
    assign it_data[0]  = d3_reg;

    // stage 1 logic
    always_comb begin
        x4 = (func0_reg == FUNC_MAG) ? ar0_reg : br0_reg;
        x5 = (func0_reg == FUNC_MAG) ? ai0_reg : bi0_reg;
        p_rr_next = ar0_reg * br0_reg;
        p_ii_next = ai0_reg * bi0_reg;
        p_ri_next = ar0_reg * bi0_reg;
        p_ir_next = ai0_reg * br0_reg;
        p_s4_next = x4 * x4;
        p_s5_next = x5 * x5;
        s_re = 33'd0;
        s_im = 33'd0;
        rr1_next = '0;
        ri1_next = '0;
        st1_next = ST_OK;
        case (func0_reg)
            FUNC_ADD: begin
                s_re = {ar0_reg[31], ar0_reg} + {br0_reg[31], br0_reg};
                s_im = {ai0_reg[31], ai0_reg} + {bi0_reg[31], bi0_reg};
            end
            FUNC_SUB: begin
                s_re = {ar0_reg[31], ar0_reg} - {br0_reg[31], br0_reg};
                s_im = {ai0_reg[31], ai0_reg} - {bi0_reg[31], bi0_reg};
            end
            default: begin
                s_re = 33'd0;
                s_im = 33'd0;
            end
        endcase
        fin_re   = sat33(s_re);
        fin_im   = sat33(s_im);
        rr1_next = fin_re[31:0];
        ri1_next = fin_im[31:0];
        st1_next = (fin_re[32] || fin_im[32]) ? ST_SAT : ST_OK;
    end

    // stage 2 logic
    always_comb begin
        re2_next = {p_rr_reg[63], p_rr_reg} + {p_ii_reg[63], p_ii_reg};
        im2_next = {p_ir_reg[63], p_ir_reg} - {p_ri_reg[63], p_ri_reg};
        if (func1_reg == FUNC_MUL) begin
            re2_next = {p_rr_reg[63], p_rr_reg} - {p_ii_reg[63], p_ii_reg};
            im2_next = {p_ri_reg[63], p_ri_reg} + {p_ir_reg[63], p_ir_reg};
        end
        sq2_next = $unsigned(p_s4_reg) + $unsigned(p_s5_reg);
    end

    // stage 3 logic
    always_comb begin
        neg_re_v = 65'd0 - re2_reg;
        neg_im_v = 65'd0 - im2_reg;
        mag_re   = re2_reg[64] ? neg_re_v[63:0] : re2_reg[63:0];
        mag_im   = im2_reg[64] ? neg_im_v[63:0] : im2_reg[63:0];
        sh_re    = 65'($signed(re2_reg) >>> 16);
        sh_im    = 65'($signed(im2_reg) >>> 16);
        sat_a    = 1'b0;
        sat_b    = 1'b0;
        d3_next.den     = sq2_reg;
        d3_next.rem_re  = {16'd0, mag_re[63:16]};
        d3_next.rem_im  = {16'd0, mag_im[63:16]};
        d3_next.lo_re   = mag_re[15:0];
        d3_next.lo_im   = mag_im[15:0];
        d3_next.q_re    = '0;
        d3_next.q_im    = '0;
        d3_next.neg_re  = re2_reg[64];
        d3_next.neg_im  = im2_reg[64];
        d3_next.ovf_re  = ({16'd0, mag_re[63:16]} >= sq2_reg);
        d3_next.ovf_im  = ({16'd0, mag_im[63:16]} >= sq2_reg);
        d3_next.sq_n    = sq2_reg;
        d3_next.sq_rem  = '0;
        d3_next.sq_root = '0;
        d3_next.is_div  = 1'b0;
        d3_next.is_mag  = 1'b0;
        d3_next.rr      = rr2_reg;
        d3_next.ri      = ri2_reg;
        d3_next.st      = st2_reg;
        case (func2_reg)
            FUNC_MUL: begin
                {sat_a, d3_next.rr} = sat65(sh_re);
                {sat_b, d3_next.ri} = sat65(sh_im);
                d3_next.st = (sat_a || sat_b) ? ST_SAT : ST_OK;
            end
            FUNC_DIV: begin
                if (sq2_reg == 64'd0) begin
                    d3_next.rr = '0;
                    d3_next.ri = '0;
                    d3_next.st = ST_DIV0;
                end else begin
                    d3_next.is_div = 1'b1;
                end
            end
            FUNC_MAG: begin
                d3_next.is_mag = 1'b1;
            end
            default: begin
                d3_next.is_mag = 1'b0;
            end
        endcase
    end

    // output logic
    always_comb begin
        fin         = it_data[ITER_STEPS];
        res_re_next = fin.rr;
        res_im_next = fin.ri;
        res_st_next = fin.st;
        dq_re       = fin_div(fin.neg_re, fin.ovf_re, fin.q_re);
        dq_im       = fin_div(fin.neg_im, fin.ovf_im, fin.q_im);
        if (fin.is_div) begin
            res_re_next = dq_re[31:0];
            res_im_next = dq_im[31:0];
            res_st_next = (dq_re[32] || dq_im[32]) ? ST_SAT : ST_OK;
        end else if (fin.is_mag) begin
            res_re_next = fin.sq_root[31] ? Q_MAX : fin.sq_root;
            res_im_next = '0;
            res_st_next = fin.sq_root[31] ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv0) begin
                v0_reg <= s_tvalid;
            end
            if (adv1) begin
                v1_reg <= v0_reg;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (it_adv[0]) begin
                v3_reg <= v2_reg;
            end
            if (adv_out) begin
                m_valid_reg <= it_valid[ITER_STEPS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv0) begin
            func0_reg <= s_tdata[2:0];
            ar0_reg   <= s_tdata[34:3];
            ai0_reg   <= s_tdata[66:35];
            br0_reg   <= s_tdata[98:67];
            bi0_reg   <= s_tdata[130:99];
        end
        if (adv1) begin
            func1_reg <= func0_reg;
            p_rr_reg  <= p_rr_next;
            p_ii_reg  <= p_ii_next;
            p_ri_reg  <= p_ri_next;
            p_ir_reg  <= p_ir_next;
            p_s4_reg  <= p_s4_next;
            p_s5_reg  <= p_s5_next;
            rr1_reg   <= rr1_next;
            ri1_reg   <= ri1_next;
            st1_reg   <= st1_next;
        end
        if (adv2) begin
            func2_reg <= func1_reg;
            re2_reg   <= re2_next;
            im2_reg   <= im2_next;
            sq2_reg   <= sq2_next;
            rr2_reg   <= rr1_reg;
            ri2_reg   <= ri1_reg;
            st2_reg   <= st1_reg;
        end
        if (it_adv[0]) begin
            d3_reg <= d3_next;
        end
        if (adv_out) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            res_st_reg <= res_st_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_st_reg, res_im_reg, res_re_reg};

endmodule

// ----- tb/complex_arithmetic_unit_test.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_test
// Streams directed and random complex operand pairs through the unit, predicts
// each result in Q16.16 at full width, and compares every output transaction.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [Q_W-1:0]    ar;
        logic [Q_W-1:0]    ai;
        logic [Q_W-1:0]    br;
        logic [Q_W-1:0]    bi;
    } op_item_t;

    typedef struct packed {
        logic [Q_W-1:0]    rr;
        logic [Q_W-1:0]    ri;
        logic [STAT_W-1:0] st;
    } res_item_t;

    localparam int WATCHDOG    = 20000;
    localparam int DRAIN       = 60;
    localparam int HOLD_CYCLES = 200;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;

    op_item_t  pending_ops[$];
    res_item_t expected_results[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  calm = 0;
    bit  hold_sink = 0;
    int  hold_cnt = 0;
    bit  stim_done = 0;
    int  src_gap = 0;
    int  sink_gap = 0;

    complex_arithmetic_unit DUT (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] sat_signed(input logic signed [127:0] v, inout bit sat);
        if (v > 128'sd2147483647) begin
            sat = 1;
            return Q_MAX;
        end
        if (v < -128'sd2147483648) begin
            sat = 1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag << 16) / den;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] cand;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if ({64'd0, cand} * cand <= {64'd0, n}) r = cand;
        end
        return r;
    endfunction

    function automatic res_item_t predict_complex(input op_item_t op);
        res_item_t res;
        logic signed [127:0] ar, ai, br, bi, x, y, den;
        bit sat;
        ar = $signed(op.ar);
        ai = $signed(op.ai);
        br = $signed(op.br);
        bi = $signed(op.bi);
        sat = 0;
        res = '0;
        case (op.func)
            FUNC_ADD: begin
                res.rr = sat_signed(ar + br, sat);
                res.ri = sat_signed(ai + bi, sat);
            end
            FUNC_SUB: begin
                res.rr = sat_signed(ar - br, sat);
                res.ri = sat_signed(ai - bi, sat);
            end
            FUNC_MUL: begin
                x = ar * br - ai * bi;
                y = ar * bi + ai * br;
                res.rr = sat_signed(x >>> 16, sat);
                res.ri = sat_signed(y >>> 16, sat);
            end
            FUNC_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    res.st = ST_DIV0;
                end else begin
                    res.rr = sat_signed(div_trunc(ar * br + ai * bi, den), sat);
                    res.ri = sat_signed(div_trunc(ai * br - ar * bi, den), sat);
                end
            end
            FUNC_MAG: begin
                x = ar * ar + ai * ai;
                res.rr = sat_signed($signed({64'd0, root_floor(x[63:0])}), sat);
            end
            default: ;
        endcase
        if (sat && res.st == ST_OK) res.st = ST_SAT;
        return res;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0001_0000;
            4, 5: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            6: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input logic [2:0] f, input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi);
        op_item_t op;
        op = '{f, ar, ai, br, bi};
        pending_ops.push_back(op);
    endtask

    // driver
    always @(posedge aclk) begin
        op_item_t op;
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(predict_complex(op_item_t'(
                {s_tdata[2:0], s_tdata[34:3], s_tdata[66:35], s_tdata[98:67], s_tdata[130:99]})));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 0;
                end else if (pending_ops.size() > 0) begin
                    op = pending_ops.pop_front();
                    s_tdata <= {5'd0, op.bi, op.br, op.ai, op.ar, op.func};
                    s_tvalid <= 1;
                    if (!calm && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 11);
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver stall control
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_sink && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            m_tready <= 0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
            if (!calm && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 11);
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_item_t got;
        res_item_t exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = res_item_t'({m_tdata[31:0], m_tdata[63:32], m_tdata[65:64]});
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.rr !== exp_r.rr) begin
                        $display("%0t: res_real expected %h actual %h", $time, exp_r.rr, got.rr);
                        errors++;
                    end
                    if (got.ri !== exp_r.ri) begin
                        $display("%0t: res_imag expected %h actual %h", $time, exp_r.ri, got.ri);
                        errors++;
                    end
                    if (got.st !== exp_r.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, exp_r.st, got.st);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [2:0] f;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        add_op(FUNC_ADD, Q_MAX, Q_MIN, 32'd1, 32'hFFFF_FFFF);
        add_op(FUNC_ADD, 32'h0001_8000, 32'h0, 32'hFFFF_0000, 32'h0002_0000);
        add_op(FUNC_SUB, Q_MIN, Q_MAX, 32'd1, 32'hFFFF_FFFF);
        add_op(FUNC_SUB, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        add_op(FUNC_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        add_op(FUNC_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
        add_op(FUNC_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
        add_op(FUNC_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
        add_op(FUNC_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        add_op(FUNC_DIV, Q_MAX, Q_MIN, 32'h0, 32'h0);
        add_op(FUNC_DIV, 32'h0001_0000, 32'h0, 32'h0000_0001, 32'h0);
        add_op(FUNC_DIV, 32'hFFFF_0000, 32'h0, 32'h0000_0001, 32'h0);
        add_op(FUNC_DIV, 32'h0001_0000, 32'h0000_0001, 32'h0003_0000, 32'h0);
        add_op(FUNC_DIV, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        add_op(FUNC_DIV, 32'h0000_0001, 32'hFFFF_FFFF, Q_MAX, Q_MAX);
        add_op(FUNC_MAG, Q_MIN, Q_MIN, 32'h0, 32'h0);
        add_op(FUNC_MAG, 32'h0003_0000, 32'h0004_0000, Q_MAX, Q_MAX);
        add_op(FUNC_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
        add_op(FUNC_MAG, Q_MAX, 32'h0, 32'h0, 32'h0);
        add_op(3'd5, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_op(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
        add_op(3'd7, Q_MIN, Q_MIN, Q_MIN, Q_MIN);

        for (int i = 0; i < 2000; i++) begin
            f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            if (f == FUNC_DIV && $urandom_range(0, 15) == 0) begin
                add_op(f, rand_q(), rand_q(), 32'd0, 32'd0);
            end else begin
                add_op(f, rand_q(), rand_q(), rand_q(), rand_q());
            end
            if (i == 300) begin
                wait (pending_ops.size() == 0);
                hold_sink = 1;
                add_op(FUNC_MUL, rand_q(), rand_q(), rand_q(), rand_q());
            end
            if (i == 1000) begin
                wait (pending_ops.size() == 0 && expected_results.size() == 0 && !s_tvalid);
            end
            if (i == 1700) calm = 1;
        end
        wait (pending_ops.size() == 0 && !s_tvalid);
        stim_done = 1;
        wait (expected_results.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/cau_pkg.sv
hdl/cau_iter_stage.sv
hdl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_test.sv
